### sv/mlp_pkg.sv
// Shared types, widths and the sigmoid lookup table for the 4-4-4-1 perceptron.
// No dependencies; imported by every module of the block except mlp_checker.
`default_nettype none

package mlp_pkg;

    // Fixed-point format of features, weights and activations (Q2.F)
    localparam int FRAC_BITS  = 6;
    localparam int SIG_DEPTH  = 1024;

    localparam int BYTE_W     = 8;
    localparam int ACT_W      = FRAC_BITS + 1;                      // 0 .. 2^F
    localparam int SRC_W      = (ACT_W + 1 > BYTE_W) ? ACT_W + 1 : BYTE_W;
    localparam int SUM_W      = SRC_W + BYTE_W + 3;                 // 4 products + bias
    localparam int OUT_W      = 17;                                 // Q5.2F result field

    // Hidden sums saturate to [-L, L-1], L = 8 << 2F
    localparam int SUM_LIMIT  = 8 << (2 * FRAC_BITS);
    localparam int LIM_W      = $clog2(2 * SUM_LIMIT);
    localparam int IDX_W      = $clog2(SIG_DEPTH);
    localparam int IDX_SHIFT  = LIM_W - IDX_W;

    localparam int N_UNITS    = 4;
    localparam int W_WORD_W   = N_UNITS * N_UNITS * BYTE_W;         // one layer of weights
    localparam int B_WORD_W   = N_UNITS * BYTE_W;                   // one layer of biases
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_CFG_W  = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L1_LO  = 3'd0,
        CFG_L1_HI  = 3'd1,
        CFG_L2_LO  = 3'd2,
        CFG_L2_HI  = 3'd3,
        CFG_BIAS   = 3'd4,
        CFG_OUT_WB = 3'd5
    } t_cfg_idx;

    typedef logic        [ACT_W-1:0] t_act;
    typedef t_act        [N_UNITS-1:0] t_act_vec;
    typedef logic signed [SRC_W-1:0] t_src;
    typedef t_src        [N_UNITS-1:0] t_src_vec;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef t_sum        [N_UNITS-1:0] t_sum_vec;
    typedef logic        [IDX_W-1:0] t_sig_idx;
    typedef t_act        t_sig_rom [SIG_DEPTH];

    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    // e^-1 unit step in Q30 (series to the third order term)
    localparam longint unsigned EXP_BASE = Q30_ONE - (Q30_ONE >> (2 * FRAC_BITS))
                                         + (Q30_ONE >> (4 * FRAC_BITS + 1))
                                         - (Q30_ONE >> (6 * FRAC_BITS)) / 6;

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // Unsigned long division by shift and subtract; used only to build the table
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Evaluated at elaboration: e^-|x| by square-and-multiply in Q30, then
    // the rounded logistic value in Q2.F.
    function automatic t_sig_rom build_sig_rom();
        t_sig_rom        rom;
        longint unsigned base;
        longint unsigned acc;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned num;
        longint          x;
        for (int i = 0; i < SIG_DEPTH; i++) begin
            x   = -longint'(SUM_LIMIT)
                + longint'(((2 * longint'(i) + 1) * longint'(SUM_LIMIT)) / SIG_DEPTH);
            mag = (x < 0) ? longint'(-x) : longint'(x);
            acc  = Q30_ONE;
            base = EXP_BASE;
            for (int b = 0; b < LIM_W; b++) begin
                if (mag[b]) begin
                    acc = q30_mul(acc, base);
                end
                base = q30_mul(base, base);
            end
            den = Q30_ONE + acc;
            num = ((x >= 0) ? Q30_ONE : acc) << FRAC_BITS;
            rom[i] = ACT_W'(udiv64(2 * num + den, 2 * den));
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = build_sig_rom();

endpackage

`default_nettype wire

### sv/mlp_layer_mac.sv
// One hidden layer: four units, each a four-term dot product plus shifted bias.
// Registered output stage with valid/ready; uses mlp_pkg.
`default_nettype none

module mlp_layer_mac (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  mlp_pkg::t_src_vec                    i_src,
    input  wire  [mlp_pkg::W_WORD_W-1:0]         i_weights,  // byte unit*4+source
    input  wire  [mlp_pkg::B_WORD_W-1:0]         i_biases,   // byte per unit
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output mlp_pkg::t_sum_vec                    o_sum
);
    import mlp_pkg::*;

    logic     r_valid;
    t_sum_vec r_sum;
    t_sum_vec n_sum;
    logic     load;

    always_comb begin
        t_sum acc;
        acc = '0;
        for (int u = 0; u < N_UNITS; u++) begin
            acc = t_sum'($signed(i_biases[u*BYTE_W +: BYTE_W])) <<< FRAC_BITS;
            for (int j = 0; j < N_UNITS; j++) begin
                acc = acc + t_sum'($signed(i_weights[(u*N_UNITS + j)*BYTE_W +: BYTE_W]))
                          * t_sum'($signed(i_src[j]));
            end
            n_sum[u] = acc;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

### sv/mlp_sigmoid.sv
// Four-lane sigmoid stage: saturate each hidden sum, index the constant table.
// Registered output stage with valid/ready; uses mlp_pkg.
`default_nettype none

module mlp_sigmoid (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  mlp_pkg::t_sum_vec  i_sum,
    output logic               o_valid,
    input  wire                i_ready,
    output mlp_pkg::t_act_vec  o_act
);
    import mlp_pkg::*;

    logic     r_valid;
    t_act_vec r_act;
    t_act_vec n_act;
    logic     load;

    always_comb begin
        t_sum     sat;
        t_sum     off;
        t_sig_idx idx;
        sat = '0;
        off = '0;
        idx = '0;
        for (int u = 0; u < N_UNITS; u++) begin
            if (i_sum[u] < -t_sum'(SUM_LIMIT)) begin
                sat = -t_sum'(SUM_LIMIT);
            end else if (i_sum[u] > t_sum'(SUM_LIMIT - 1)) begin
                sat = t_sum'(SUM_LIMIT - 1);
            end else begin
                sat = i_sum[u];
            end
            // Offset into [0, 2L) and keep the top bits as the table index
            off = sat + t_sum'(SUM_LIMIT);
            idx = off[LIM_W-1 -: IDX_W];
            n_act[u] = SIG_ROM[idx];
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_act <= n_act;
        end
    end

    assign o_valid = r_valid;
    assign o_act   = r_act;

endmodule

`default_nettype wire

### sv/mlp_out_mac.sv
// Output unit: dot product of layer-two activations plus shifted bias, sign test.
// Acts as the block's output register; uses mlp_pkg.
`default_nettype none

module mlp_out_mac (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  mlp_pkg::t_act_vec             i_act,
    input  wire  [mlp_pkg::OUT_CFG_W-1:0] i_weights_bias,  // bytes 0-3 weights, 4 bias
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic                          o_act_now,
    output logic signed [mlp_pkg::OUT_W-1:0] o_output_sum
);
    import mlp_pkg::*;

    logic                    r_valid;
    logic                    r_act_now;
    logic signed [OUT_W-1:0] r_sum;
    t_sum                    n_sum;
    logic                    load;

    always_comb begin
        n_sum = t_sum'($signed(i_weights_bias[N_UNITS*BYTE_W +: BYTE_W])) <<< FRAC_BITS;
        for (int j = 0; j < N_UNITS; j++) begin
            n_sum = n_sum + t_sum'($signed(i_weights_bias[j*BYTE_W +: BYTE_W]))
                          * t_sum'({1'b0, i_act[j]});
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sum     <= n_sum[OUT_W-1:0];
            r_act_now <= !n_sum[SUM_W-1] && (n_sum != '0);
        end
    end

    assign o_valid      = r_valid;
    assign o_act_now    = r_act_now;
    assign o_output_sum = r_sum;

endmodule

`default_nettype wire

### sv/mlp_4_4_4_1_inference_unit.sv
// Top level of the 4-4-4-1 perceptron decision block: config registers and
// the five-stage pipeline. Depends on mlp_pkg, mlp_layer_mac, mlp_sigmoid, mlp_out_mac.
//
// Usage:
//   s_axis carries one item of four signed Q2.6 features; m_axis returns one
//   item per input: the decision bit and the Q5.12 output pre-activation.
//   Weights and biases sit in six registers written through i_cfg_we /
//   i_cfg_index / i_cfg_data; write them only while no item is in flight.
//   Pipeline: layer-one MAC, sigmoid lookup, layer-two MAC, sigmoid lookup,
//   output MAC. Each stage owns a register with a valid bit.
//   Throughput: one item per cycle while the output is not stalled.
//   Stall: each stage holds its item while the next one is full and not
//   taking; bubbles still fill, so s_axis_tready stays high until every
//   stage holds an item. Nothing is dropped or repeated.
//   Reset (synchronous, i_rst_n low): clear all valid bits and zero all
//   weight and bias registers; the sigmoid table is constant logic.
`default_nettype none

module mlp_4_4_4_1_inference_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] height_feature, [15:8] speed_feature,
    // [23:16] obstacle_distance_feature, [31:24] gap_offset_feature
    input  wire  [31:0] s_axis_tdata,
    // Result items
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [0] act_now, [17:1] output_sum, [23:18] zero
    output logic [23:0] m_axis_tdata,
    // Configuration writes
    input  wire                             i_cfg_we,
    input  wire  [mlp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [mlp_pkg::CFG_W-1:0]       i_cfg_data
);
    import mlp_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0]     r_l1_lo;
    logic [CFG_W-1:0]     r_l1_hi;
    logic [CFG_W-1:0]     r_l2_lo;
    logic [CFG_W-1:0]     r_l2_hi;
    logic [CFG_W-1:0]     r_bias;
    logic [OUT_CFG_W-1:0] r_out_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_lo  <= '0;
            r_l1_hi  <= '0;
            r_l2_lo  <= '0;
            r_l2_hi  <= '0;
            r_bias   <= '0;
            r_out_wb <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_L1_LO:  r_l1_lo  <= i_cfg_data;
                CFG_L1_HI:  r_l1_hi  <= i_cfg_data;
                CFG_L2_LO:  r_l2_lo  <= i_cfg_data;
                CFG_L2_HI:  r_l2_hi  <= i_cfg_data;
                CFG_BIAS:   r_bias   <= i_cfg_data;
                CFG_OUT_WB: r_out_wb <= i_cfg_data[OUT_CFG_W-1:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // Unpack the features into signed MAC sources
    t_src_vec feat;

    always_comb begin
        for (int j = 0; j < N_UNITS; j++) begin
            feat[j] = t_src'($signed(s_axis_tdata[j*BYTE_W +: BYTE_W]));
        end
    end

    // Stage handshakes
    logic     v1, v2, v3, v4;
    logic     rdy2, rdy3, rdy4, rdy5;
    t_sum_vec sum1, sum3;
    t_act_vec act2, act4;
    t_src_vec src3;
    logic                    act_now;
    logic signed [OUT_W-1:0] out_sum;

    mlp_layer_mac u_layer1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_src     (feat),
        .i_weights ({r_l1_hi, r_l1_lo}),
        .i_biases  (r_bias[B_WORD_W-1:0]),
        .o_valid   (v1),
        .i_ready   (rdy2),
        .o_sum     (sum1)
    );

    mlp_sigmoid u_sig1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .o_ready (rdy2),
        .i_sum   (sum1),
        .o_valid (v2),
        .i_ready (rdy3),
        .o_act   (act2)
    );

    // Activations are 0..2^F: zero-extend into the signed source width
    always_comb begin
        for (int j = 0; j < N_UNITS; j++) begin
            src3[j] = t_src'({1'b0, act2[j]});
        end
    end

    mlp_layer_mac u_layer2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (v2),
        .o_ready   (rdy3),
        .i_src     (src3),
        .i_weights ({r_l2_hi, r_l2_lo}),
        .i_biases  (r_bias[CFG_W-1:B_WORD_W]),
        .o_valid   (v3),
        .i_ready   (rdy4),
        .o_sum     (sum3)
    );

    mlp_sigmoid u_sig2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v3),
        .o_ready (rdy4),
        .i_sum   (sum3),
        .o_valid (v4),
        .i_ready (rdy5),
        .o_act   (act4)
    );

    mlp_out_mac u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (v4),
        .o_ready        (rdy5),
        .i_act          (act4),
        .i_weights_bias (r_out_wb),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_act_now      (act_now),
        .o_output_sum   (out_sum)
    );

    assign m_axis_tdata = {6'd0, out_sum, act_now};

endmodule

`default_nettype wire

### sv/mlp_checker.sv
// Port-level checks on the result channel of the perceptron block, and the
// bind that attaches them to mlp_4_4_4_1_inference_unit.
`default_nettype none

module mlp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata
);

    // A stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Decision bit agrees with the sign of the output sum
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[0] == (!m_axis_tdata[17] && m_axis_tdata[17:1] != 17'd0))
        else $error("act_now disagrees with output_sum");

    // Padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
        else $error("nonzero padding in result");

    // Nothing comes out in the cycle after reset
    a_rst: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind mlp_4_4_4_1_inference_unit mlp_checker u_mlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### dv/tb_mlp_4_4_4_1_inference_unit.sv
// Self-checking testbench for the 4-4-4-1 perceptron decision block.
// Predicts each decision and output sum in place and checks every result item.
// Depends on mlp_pkg and mlp_4_4_4_1_inference_unit only.

module tb_mlp_4_4_4_1_inference_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point format and table geometry of the block under test
    localparam int  FB        = mlp_pkg::FRAC_BITS;
    localparam int  LUT_DEPTH = mlp_pkg::SIG_DEPTH;
    localparam longint SAT_LIM = longint'(8) << (2 * FB);
    localparam longint unsigned ONE_Q30  = 64'd1 << 30;
    localparam longint unsigned HALF_Q30 = 64'd1 << 29;

    // Register indexes past the last register; writes there must change nothing
    localparam int CFG_SPARE_FIRST = 6;
    localparam int CFG_SPARE_LAST  = 7;
    localparam logic [63:0] OUT_WB_MASK = (64'd1 << mlp_pkg::OUT_CFG_W) - 64'd1;

    localparam int RESET_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int IDLE_PCT     = 13;    // idle chance per cycle on each side
    localparam int TAIL_CYCLES  = 12;    // settle time after the last result
    localparam int STALL_LIMIT  = 4000;  // cycles without any accepted item

    typedef enum int {STYLE_FULL, STYLE_SMALL, STYLE_EXTREME} cfg_style_e;

    typedef struct packed {
        logic [16:0] output_sum;
        logic        act_now;
    } decision_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic                            i_cfg_we = 1'b0;
    logic [mlp_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [mlp_pkg::CFG_W-1:0]       i_cfg_data = '0;

    mlp_4_4_4_1_inference_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: register copies, the sigmoid table, pending decisions
    logic [63:0] cfg_shadow [6];
    logic [63:0] cfg_stage  [6];
    int          logistic_tbl [LUT_DEPTH];
    decision_t   expected_decisions [$];
    int          mismatch_count = 0;

    // Traffic shaping, set by the tests
    bit          tx_no_idle = 1'b0;
    bit          rx_no_idle = 1'b0;
    int          rx_hold_req = 0;
    int          rx_hold_ack = 0;
    int          rx_hold_left = 0;
    int          stall_count = 0;

    // e^-n in Q30, n in units of 2^-2F, by square-and-multiply with rounding
    function automatic longint unsigned exp_neg_q30(longint unsigned n);
        longint unsigned b;
        longint unsigned acc;
        b = ONE_Q30 - (ONE_Q30 >> (2 * FB)) + (ONE_Q30 >> (4 * FB + 1))
          - (ONE_Q30 >> (6 * FB)) / 6;
        acc = ONE_Q30;
        while (n != 0) begin
            if (n[0]) begin
                acc = (acc * b + HALF_Q30) >> 30;
            end
            b = (b * b + HALF_Q30) >> 30;
            n = n >> 1;
        end
        return acc;
    endfunction

    function automatic void build_logistic_tbl();
        longint          x;
        longint unsigned mag;
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            x   = -SAT_LIM + ((2 * longint'(i) + 1) * SAT_LIM) / LUT_DEPTH;
            mag = (x < 0) ? longint'(-x) : longint'(x);
            e   = exp_neg_q30(mag);
            den = ONE_Q30 + e;
            num = ((x >= 0) ? ONE_Q30 : e) << FB;
            logistic_tbl[i] = int'((2 * num + den) / (2 * den));
        end
    endfunction

    function automatic int sbyte(logic [63:0] w, int k);
        logic signed [7:0] b;
        b = w[k*8 +: 8];
        return int'(b);
    endfunction

    // Saturate a hidden sum and look its activation up
    function automatic int activation(longint s);
        longint idx;
        if (s < -SAT_LIM) s = -SAT_LIM;
        if (s > SAT_LIM - 1) s = SAT_LIM - 1;
        idx = ((s + SAT_LIM) * LUT_DEPTH) / (2 * SAT_LIM);
        if (idx >= LUT_DEPTH) idx = LUT_DEPTH - 1;
        return logistic_tbl[idx];
    endfunction

    function automatic decision_t predict_decision(logic [31:0] feats);
        int          x  [4];
        int          h1 [4];
        int          h2 [4];
        longint      s;
        logic [63:0] w;
        decision_t   d;
        for (int j = 0; j < 4; j++) x[j] = int'($signed(feats[j*8 +: 8]));
        for (int u = 0; u < 4; u++) begin
            w = (u < 2) ? cfg_shadow[mlp_pkg::CFG_L1_LO] : cfg_shadow[mlp_pkg::CFG_L1_HI];
            s = longint'(sbyte(cfg_shadow[mlp_pkg::CFG_BIAS], u)) * (1 << FB);
            for (int j = 0; j < 4; j++) s += longint'(sbyte(w, (u % 2) * 4 + j)) * x[j];
            h1[u] = activation(s);
        end
        for (int u = 0; u < 4; u++) begin
            w = (u < 2) ? cfg_shadow[mlp_pkg::CFG_L2_LO] : cfg_shadow[mlp_pkg::CFG_L2_HI];
            s = longint'(sbyte(cfg_shadow[mlp_pkg::CFG_BIAS], 4 + u)) * (1 << FB);
            for (int j = 0; j < 4; j++) s += longint'(sbyte(w, (u % 2) * 4 + j)) * h1[j];
            h2[u] = activation(s);
        end
        s = longint'(sbyte(cfg_shadow[mlp_pkg::CFG_OUT_WB], 4)) * (1 << FB);
        for (int j = 0; j < 4; j++) s += longint'(sbyte(cfg_shadow[mlp_pkg::CFG_OUT_WB], j)) * h2[j];
        d.act_now    = (s > 0);
        d.output_sum = s[16:0];
        return d;
    endfunction

    function automatic logic [63:0] rand_cfg_word(cfg_style_e style);
        logic [63:0] w;
        w = {$urandom, $urandom};
        if (style != STYLE_FULL) begin
            for (int k = 0; k < 8; k++) begin
                if (style == STYLE_SMALL) w[k*8 +: 8] = 8'($urandom_range(31) - 16);
                else w[k*8 +: 8] = $urandom_range(1) ? 8'h7F : 8'h80;
            end
        end
        return w;
    endfunction

    function automatic logic [31:0] rand_features();
        logic [31:0] f;
        f = $urandom;
        for (int k = 0; k < 4; k++) begin
            // pull a feature to an edge of its range now and then
            if ($urandom_range(99) < 10) begin
                case ($urandom_range(3))
                    0: f[k*8 +: 8] = 8'h80;
                    1: f[k*8 +: 8] = 8'h7F;
                    2: f[k*8 +: 8] = 8'h00;
                    default: f[k*8 +: 8] = 8'hFF;
                endcase
            end
        end
        return f;
    endfunction

    // Write all staged registers, then junk to the unused indexes; hold the
    // block idle while doing so. Upper bits of the 40-bit register are random.
    task automatic load_registers();
        for (int k = mlp_pkg::CFG_L1_LO; k <= mlp_pkg::CFG_OUT_WB; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= mlp_pkg::CFG_IDX_W'(k);
            i_cfg_data  <= cfg_stage[k];
            @(posedge i_clk);
            cfg_shadow[k] = (k == mlp_pkg::CFG_OUT_WB) ? (cfg_stage[k] & OUT_WB_MASK)
                                                       : cfg_stage[k];
        end
        for (int k = CFG_SPARE_FIRST; k <= CFG_SPARE_LAST; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= mlp_pkg::CFG_IDX_W'(k);
            i_cfg_data  <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic stage_uniform(logic [7:0] b);
        for (int k = mlp_pkg::CFG_L1_LO; k <= mlp_pkg::CFG_OUT_WB; k++) cfg_stage[k] = {8{b}};
        cfg_stage[mlp_pkg::CFG_OUT_WB][63:40] = 24'($urandom);
    endtask

    // Offer one item and hold it until accepted; record its expected decision
    task automatic send_features(logic [31:0] feats);
        while (!tx_no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= feats;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_decisions.push_back(predict_decision(feats));
    endtask

    // Stop offering and wait for every pending decision to come back
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_decisions.size() != 0) @(posedge i_clk);
    endtask

    // Registers at reset value: every sum is zero, so the decision stays low
    task automatic test_zero_registers();
        send_features(32'h0000_0000);
        send_features(32'h7F7F_7F7F);
        send_features(32'h8080_8080);
        send_features(32'h807F_00FF);
        wait_results_done();
    endtask

    // All-max and all-min bytes drive the hidden sums past both saturation
    // limits; also check that bits above the 40-bit register are dropped
    task automatic test_saturation();
        stage_uniform(8'h7F);
        load_registers();
        send_features(32'h7F7F_7F7F);
        send_features(32'h8080_8080);
        send_features(32'h7F80_7F80);
        wait_results_done();
        stage_uniform(8'h80);
        load_registers();
        send_features(32'h7F7F_7F7F);
        send_features(32'h8080_8080);
        send_features(32'h0080_FF7F);
        wait_results_done();
    endtask

    // Zero hidden layers give every activation the sigmoid midpoint, so the
    // output weights and bias put the sum exactly at, just above, or below zero
    task automatic test_decision_boundary();
        stage_uniform(8'h00);
        cfg_stage[mlp_pkg::CFG_OUT_WB] = {24'($urandom), 40'hFF_00_00_00_02};
        load_registers();
        send_features(rand_features());
        send_features(rand_features());
        wait_results_done();
        cfg_stage[mlp_pkg::CFG_OUT_WB] = {24'($urandom), 40'hFF_00_00_01_02};
        load_registers();
        send_features(rand_features());
        send_features(rand_features());
        wait_results_done();
        cfg_stage[mlp_pkg::CFG_OUT_WB] = {24'($urandom), 40'h01_00_00_00_FD};
        load_registers();
        send_features(rand_features());
        send_features(rand_features());
        wait_results_done();
    endtask

    // Random registers in several styles, random features, random idling
    task automatic test_random_traffic();
        cfg_style_e style;
        for (int phase = 0; phase < 6; phase++) begin
            style = cfg_style_e'(phase % 3);
            for (int k = mlp_pkg::CFG_L1_LO; k <= mlp_pkg::CFG_OUT_WB; k++)
                cfg_stage[k] = rand_cfg_word(style);
            load_registers();
            repeat (120) send_features(rand_features());
            wait_results_done();
        end
    endtask

    // Stretch with no idling on either side
    task automatic test_full_rate();
        for (int k = mlp_pkg::CFG_L1_LO; k <= mlp_pkg::CFG_OUT_WB; k++)
            cfg_stage[k] = rand_cfg_word(STYLE_SMALL);
        load_registers();
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        repeat (120) send_features(rand_features());
        wait_results_done();
        rx_no_idle = 1'b0;
        tx_no_idle = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering: fill the pipeline
    // and make it stall its input
    task automatic test_output_backpressure();
        tx_no_idle = 1'b1;
        rx_hold_req = rx_hold_req + 1;
        repeat (40) send_features(rand_features());
        tx_no_idle = 1'b0;
        wait_results_done();
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_sender_pause();
        repeat (15) send_features(rand_features());
        wait_results_done();
        repeat (15) send_features(rand_features());
        wait_results_done();
    endtask

    // Receiver: random ready, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_ack) begin
            rx_hold_ack   <= rx_hold_req;
            rx_hold_left  <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= rx_no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each accepted result with the oldest pending decision
    always @(posedge i_clk) begin : check_decisions
        decision_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_decisions.size() == 0) begin
                $error("result item with no pending decision: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_decisions.pop_front();
                if (m_axis_tdata[0] !== want.act_now) begin
                    $error("act_now: expected %0b, got %0b", want.act_now, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[17:1] !== want.output_sum) begin
                    $error("output_sum: expected %0d, got %0d",
                           $signed(want.output_sum), $signed(m_axis_tdata[17:1]));
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        build_logistic_tbl();
        for (int k = mlp_pkg::CFG_L1_LO; k <= mlp_pkg::CFG_OUT_WB; k++) cfg_shadow[k] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_registers();
        test_saturation();
        test_decision_boundary();
        test_random_traffic();
        test_full_rate();
        test_output_backpressure();
        test_sender_pause();

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_decisions.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### mlp_4_4_4_1_inference_unit.f
sv/mlp_pkg.sv
sv/mlp_layer_mac.sv
sv/mlp_sigmoid.sv
sv/mlp_out_mac.sv
sv/mlp_4_4_4_1_inference_unit.sv
sv/mlp_checker.sv
dv/tb_mlp_4_4_4_1_inference_unit.sv
